[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the packet FIFO.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BPFA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define BPFA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define BPFA_ASSERT(lbl, clk, rstn, prop, msg)
`define BPFA_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[rtl/bpfa_pkg.sv]
// Package of types and constants for the bounded packet FIFO with accounting.
`default_nettype none
package bpfa_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam logic [10:0] MAX_ENTRIES_RESET = 11'd1024;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] packet_handle;
		logic        packet_present;
		logic signed [31:0] byte_size;
		logic signed [63:0] duration_us;
	} req_item_t;

	typedef struct packed {
		logic        success;
		logic [31:0] popped_handle;
		logic        popped_present;
		logic [30:0] popped_bytes;
		logic [62:0] popped_duration;
		logic [10:0] occupancy;
		logic signed [11:0] room_left;
		logic [47:0] byte_total;
		logic [62:0] duration_total;
	} rsp_item_t;

	typedef struct packed {
		logic        present;
		logic [31:0] handle;
		logic [30:0] bytes;
		logic [62:0] duration;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

[rtl/bpfa_if.sv]
// Valid/ready channel interfaces for requests and results of the packet FIFO.
`default_nettype none
interface bpfa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] packet_handle;
	logic        packet_present;
	logic signed [31:0] byte_size;
	logic signed [63:0] duration_us;

	modport source (output valid, opcode, packet_handle, packet_present, byte_size,
		duration_us, input ready);
	modport sink (input valid, opcode, packet_handle, packet_present, byte_size,
		duration_us, output ready);
endinterface

interface bpfa_rsp_if;
	logic        valid;
	logic        ready;
	logic        success;
	logic [31:0] popped_handle;
	logic        popped_present;
	logic [30:0] popped_bytes;
	logic [62:0] popped_duration;
	logic [10:0] occupancy;
	logic signed [11:0] room_left;
	logic [47:0] byte_total;
	logic [62:0] duration_total;

	modport source (output valid, success, popped_handle, popped_present, popped_bytes,
		popped_duration, occupancy, room_left, byte_total, duration_total, input ready);
	modport sink (input valid, success, popped_handle, popped_present, popped_bytes,
		popped_duration, occupancy, room_left, byte_total, duration_total, output ready);
endinterface
`default_nettype wire

[rtl/bpfa_ctrl.sv]
// Controller state machine that sequences accept and execute of each item.
`default_nettype none
module bpfa_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  rsp_ready,
	input  wire bpfa_pkg::dp_status_t  status,
	output bpfa_pkg::ctrl_cmd_t        cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && req_valid;
		cmd.commit = (state_q == ST_EXEC) && (!status.out_busy || rsp_ready);
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!status.out_busy || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[rtl/bpfa_datapath.sv]
// Datapath holding the descriptor storage, pointers, totals and result register.
`default_nettype none
module bpfa_datapath #(
	parameter int DEPTH = bpfa_pkg::DEPTH_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [10:0]          cfg_wdata,
	input  wire bpfa_pkg::ctrl_cmd_t  cmd,
	output bpfa_pkg::dp_status_t      status,
	input  wire bpfa_pkg::req_item_t  req_item,
	input  wire logic                 rsp_ready,
	output logic                      rsp_valid,
	output bpfa_pkg::rsp_item_t       rsp_item
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bpfa_pkg::entry_t mem [DEPTH];

	bpfa_pkg::req_item_t item_q;
	bpfa_pkg::entry_t    rd_q;
	bpfa_pkg::rsp_item_t rsp_q;
	logic                rsp_valid_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CW-1:0]       count_q;
	logic [47:0]         bytes_q;
	logic [62:0]         dur_q;
	logic [10:0]         max_q;

	logic [AW-1:0]       head_d;
	logic [AW-1:0]       tail_d;
	logic [CW-1:0]       count_d;
	logic [47:0]         bytes_d;
	logic [62:0]         dur_d;
	logic                ok;
	logic                do_write;
	logic                can_push;
	logic [30:0]         b_add;
	logic [62:0]         d_add;
	logic [48:0]         byte_sum;
	logic [63:0]         dur_sum;
	logic [48:0]         byte_diff;
	logic [63:0]         dur_diff;
	bpfa_pkg::entry_t    wr_entry;
	bpfa_pkg::rsp_item_t rsp_d;

	always_comb begin
		b_add = '0;
		d_add = '0;
		if (item_q.packet_present) begin
			if (!item_q.byte_size[31] && (item_q.byte_size != 32'sd0)) begin
				b_add = item_q.byte_size[30:0];
			end
			if (!item_q.duration_us[63] && (item_q.duration_us != 64'sd0)) begin
				d_add = item_q.duration_us[62:0];
			end
		end
		wr_entry.present  = item_q.packet_present;
		wr_entry.handle   = item_q.packet_present ? item_q.packet_handle : 32'd0;
		wr_entry.bytes    = b_add;
		wr_entry.duration = d_add;

		can_push  = (32'(count_q) < 32'(max_q)) && (32'(count_q) < 32'(DEPTH));
		byte_sum  = {1'b0, bytes_q} + 49'(b_add);
		dur_sum   = {1'b0, dur_q} + 64'(d_add);
		byte_diff = {1'b0, bytes_q} - 49'(rd_q.bytes);
		dur_diff  = {1'b0, dur_q} - 64'(rd_q.duration);

		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		bytes_d  = bytes_q;
		dur_d    = dur_q;
		ok       = 1'b0;
		do_write = 1'b0;
		rsp_d    = '0;

		case (bpfa_pkg::opcode_t'(item_q.opcode))
			bpfa_pkg::OP_PUSH: begin
				if (can_push) begin
					ok       = 1'b1;
					do_write = 1'b1;
					tail_d   = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
					count_d  = count_q + 1'b1;
					bytes_d  = byte_sum[48] ? '1 : byte_sum[47:0];
					dur_d    = dur_sum[63] ? '1 : dur_sum[62:0];
				end
			end
			bpfa_pkg::OP_POP: begin
				if (count_q != '0) begin
					ok      = 1'b1;
					head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_d = count_q - 1'b1;
					bytes_d = byte_diff[48] ? '0 : byte_diff[47:0];
					dur_d   = dur_diff[63] ? '0 : dur_diff[62:0];
					rsp_d.popped_handle   = rd_q.handle;
					rsp_d.popped_present  = rd_q.present;
					rsp_d.popped_bytes    = rd_q.bytes;
					rsp_d.popped_duration = rd_q.duration;
				end
			end
			bpfa_pkg::OP_CLEAR: begin
				ok      = 1'b1;
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
				bytes_d = '0;
				dur_d   = '0;
			end
			default: begin
			end
		endcase

		rsp_d.success        = ok;
		rsp_d.occupancy      = 11'(count_d);
		rsp_d.room_left      = 12'(12'(max_q) - 12'(count_d));
		rsp_d.byte_total     = bytes_d;
		rsp_d.duration_total = dur_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req_item;
			rd_q   <= mem[head_q];
		end
		if (cmd.commit && do_write) begin
			mem[tail_q] <= wr_entry;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			bytes_q     <= '0;
			dur_q       <= '0;
			max_q       <= bpfa_pkg::MAX_ENTRIES_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				count_q     <= count_d;
				bytes_q     <= bytes_d;
				dur_q       <= dur_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = rsp_valid_q;
	assign rsp_valid       = rsp_valid_q;
	assign rsp_item        = rsp_q;

endmodule
`default_nettype wire

[rtl/bounded_packet_fifo_with_accounting_top.sv]
// A taken item's result is registered when the controller leaves the execute state, which
// waits while the output register is full and not being read. No new item is taken until
// the last one has committed; the head entry is read into a register as an item is taken.
// Reset clears the state machine, pointers, occupancy and both totals and sets the limit
// to 1024; the descriptor storage is not cleared and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module bounded_packet_fifo_with_accounting_top #(
	parameter int DEPTH = bpfa_pkg::DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	bpfa_req_if.sink         req,
	bpfa_rsp_if.source       rsp
);

	bpfa_pkg::ctrl_cmd_t  cmd;
	bpfa_pkg::dp_status_t status;
	bpfa_pkg::req_item_t  req_item;
	bpfa_pkg::rsp_item_t  rsp_item;
	logic                 req_ready;
	logic                 rsp_valid;

	assign req_item.opcode         = req.opcode;
	assign req_item.packet_handle  = req.packet_handle;
	assign req_item.packet_present = req.packet_present;
	assign req_item.byte_size      = req.byte_size;
	assign req_item.duration_us    = req.duration_us;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bpfa_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.req_item  (req_item),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

	assign req.ready           = req_ready;
	assign rsp.valid           = rsp_valid;
	assign rsp.success         = rsp_item.success;
	assign rsp.popped_handle   = rsp_item.popped_handle;
	assign rsp.popped_present  = rsp_item.popped_present;
	assign rsp.popped_bytes    = rsp_item.popped_bytes;
	assign rsp.popped_duration = rsp_item.popped_duration;
	assign rsp.occupancy       = rsp_item.occupancy;
	assign rsp.room_left       = rsp_item.room_left;
	assign rsp.byte_total      = rsp_item.byte_total;
	assign rsp.duration_total  = rsp_item.duration_total;

	`BPFA_ASSERT_NEVER(a_accept_commit_excl, clk, arst_n, cmd.accept && cmd.commit, "accept and commit in the same cycle")
	`BPFA_ASSERT(a_commit_gives_valid, clk, arst_n, cmd.commit |=> rsp.valid, "commit did not present a result")
	`BPFA_ASSERT(a_one_at_a_time, clk, arst_n, cmd.accept |=> !req.ready, "new item taken while one is in execution")
	`BPFA_ASSERT(a_occupancy_bound, clk, arst_n, rsp.valid |-> (32'(rsp.occupancy) <= 32'(DEPTH)), "reported occupancy exceeds the storage depth")

endmodule
`default_nettype wire
